// ===== rtl/ppg_pkg.sv =====
// Shared types, pattern codes and sine table generation for the pattern generator.
package ppg_pkg;

	typedef enum logic [3:0] {
		PAT_TURN      = 4'd0,
		PAT_FRACTAL   = 4'd1,
		PAT_XOR       = 4'd2,
		PAT_SINE_XOR  = 4'd3,
		PAT_TRIANGLES = 4'd4,
		PAT_RECTS     = 4'd5,
		PAT_CUBES     = 4'd6,
		PAT_SCOTLAND  = 4'd7,
		PAT_CHAOTIC   = 4'd8
	} pattern_t;

	typedef enum logic [1:0] {
		REG_PATTERN  = 2'd0,
		REG_CONTRAST = 2'd1
	} reg_index_t;

	localparam logic [7:0] MID_GREY = 8'd128;
	localparam logic [7:0] CONTRAST_RESET = 8'd255;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	// Taylor denominators (2n)(2n+1) for n = 1..10
	localparam logic [63:0] Taylor_den [1:10] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210, 64'd272, 64'd342, 64'd420
	};

	// floor(127.5 + 127.5*sin(k*pi/128)), k in 0..64, Q2.30 series
	function automatic logic [7:0] quarter_entry(input int k);
		logic [63:0] th;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] res;
		th = '0;
		x2 = '0;
		term = '0;
		sum = '0;
		res = '0;
		if (k == 0) begin
			res = 64'd127;
		end else if (k >= 64) begin
			res = 64'd255;
		end else begin
			th = (64'(k) * PI_Q30) >> 7;
			x2 = (th * th) >> 30;
			term = th;
			sum = signed'(th);
			for (int n = 1; n <= 10; n++) begin
				term = ((term * x2) >> 30) / Taylor_den[n];
				if ((n % 2) == 1) begin
					sum = sum - signed'(term);
				end else begin
					sum = sum + signed'(term);
				end
			end
			if (sum < 0) begin
				sum = '0;
			end
			if (sum > signed'(ONE_Q30)) begin
				sum = signed'(ONE_Q30);
			end
			res = ((ONE_Q30 + unsigned'(sum)) * 64'd255) >> 31;
		end
		return res[7:0];
	endfunction

	function automatic logic [7:0] sine_entry(input int i);
		int q;
		int r;
		logic [7:0] v;
		q = (i / 64) % 4;
		r = i % 64;
		v = '0;
		unique case (q)
			0: v = quarter_entry(r);
			1: v = quarter_entry(64 - r);
			2: v = 8'd254 - quarter_entry(r);
			default: v = (r == 0) ? 8'd0 : 8'd254 - quarter_entry(64 - r);
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/procedural_pattern_pixel_generator.sv =====
// Procedural pattern pixel generator: coordinate in, contrast-scaled grey value out.
//
// Usage:
//  - Input channel (in_valid/in_ready, coord_x, coord_y): one pixel coordinate per
//    transaction. Only the low 8 bits of each coordinate affect the result.
//  - Output channel (out_valid/out_ready, pixel_value): one grey value per input
//    transaction, in order.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 selects the
//    pattern (low 4 bits), index 1 sets the contrast. cfg_ready is always high;
//    write only while no pixel is in flight.
//  - Pipeline: each accepted coordinate passes through these registered stages:
//    Stage 1 registers coordinates, stage 2 evaluates the pattern (incl. the sine
//    and cosine table lookup), stage 3 multiplies by contrast, stage 4 divides by
//    255 and re-centers on mid-grey.
//  - Throughput: one pixel per clock; the pipeline moves whenever the output
//    register is empty or being taken.
//  - Receiver stall: the whole pipeline holds, in_ready drops, nothing is lost.
//  - Reset (arst_n low): all stages empty, pattern 0 (turn), contrast 255.
module procedural_pattern_pixel_generator
	import ppg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [14:0] coord_x,
	input  logic [14:0] coord_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  pixel_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	// Sine table as constant logic; cosine is the sine at index + 64
	logic [7:0] sine_rom [256];
	for (genvar g = 0; g < 256; g++) begin : g_rom
		localparam logic [7:0] ENTRY = sine_entry(g);
		assign sine_rom[g] = ENTRY;
	end

	pattern_t   pattern_q;
	logic [7:0] contrast_q;

	logic       valid_s1, valid_s2, valid_s3, valid_s4;
	logic [7:0] x_s1, y_s1;
	logic [7:0] pat_s2;
	logic signed [16:0] prod_s3;
	logic [7:0] pix_s4;

	logic advance;
	assign advance = !valid_s4 || out_ready;
	assign in_ready = advance;
	assign cfg_ready = 1'b1;
	assign out_valid = valid_s4;
	assign pixel_value = pix_s4;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PAT_TURN;
			contrast_q <= CONTRAST_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_PATTERN) begin
				pattern_q <= pattern_t'(cfg_data[3:0]);
			end else if (cfg_index == REG_CONTRAST) begin
				contrast_q <= cfg_data;
			end
		end
	end

	// Stage 2 pattern evaluation; all math wraps at 8 bits
	logic [7:0] pat_c;
	logic [7:0] sin_idx, cos_idx;
	logic [7:0] sh_y, sh_x;
	always_comb begin
		sin_idx = (x_s1 + y_s1) ^ (y_s1 - x_s1);
		cos_idx = ((x_s1 - y_s1) ^ (y_s1 + x_s1)) + 8'd64;
		sh_y = x_s1[2] ? {y_s1[3:0], 4'b0} : y_s1;
		sh_x = y_s1[2] ? {x_s1[3:0], 4'b0} : x_s1;
		unique case (pattern_q)
			PAT_TURN:      pat_c = ((x_s1[1:0] + y_s1[1:0]) != 2'd0) ? 8'd255 : 8'd0;
			PAT_FRACTAL:   pat_c = (x_s1 - (x_s1 ^ y_s1)) + (y_s1 - (x_s1 ^ y_s1));
			PAT_XOR:       pat_c = (x_s1 - y_s1) ^ (y_s1 + x_s1);
			PAT_SINE_XOR:  pat_c = sine_rom[sin_idx] + sine_rom[cos_idx];
			PAT_TRIANGLES: pat_c = ((x_s1 ^ 8'h91) + (y_s1 ^ 8'h1f))
				^ ((x_s1 ^ 8'h56) + (y_s1 ^ 8'hf9));
			PAT_RECTS:     pat_c = ((x_s1 ^ 8'ha8) + (x_s1 ^ 8'h8b))
				^ ((y_s1 ^ 8'h3f) - (y_s1 ^ 8'he2));
			PAT_CUBES:     pat_c = ((x_s1 - 8'h4e) ^ (y_s1 + 8'h14))
				- ((y_s1 - 8'hab) ^ (x_s1 + 8'he9));
			PAT_SCOTLAND:  pat_c = ((x_s1 | 8'h4e) + (x_s1 & 8'h14))
				^ ((y_s1 & 8'hab) - (y_s1 | 8'he9));
			PAT_CHAOTIC:   pat_c = (x_s1 ^ sh_y) + (y_s1 ^ sh_x);
			default:       pat_c = MID_GREY;
		endcase
	end

	// Stage 4 divide by 255, truncating toward zero
	logic [15:0] mag;
	logic [16:0] qsum;
	logic [7:0]  quo;
	logic [7:0]  res_c;
	always_comb begin
		mag = prod_s3[16] ? 16'(-prod_s3) : prod_s3[15:0];
		qsum = 17'(mag) + 17'd1 + 17'(mag[15:8]);
		quo = qsum[15:8];
		res_c = prod_s3[16] ? (MID_GREY - quo) : (MID_GREY + quo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1 <= coord_x[7:0];
			y_s1 <= coord_y[7:0];
			pat_s2 <= pat_c;
			prod_s3 <= (signed'({1'b0, pat_s2}) - 17'sd128) * signed'({9'b0, contrast_q});
			pix_s4 <= res_c;
		end
	end

endmodule

// ===== bench/ppg_checker.sv =====
// Checker for the pattern generator: tracks register writes, predicts each pixel, compares.
module ppg_checker
	import ppg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [14:0] coord_x,
	input  logic [14:0] coord_y,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  pixel_value,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          fail_count,
	output int          pixels_waiting,
	output int          pixels_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned PI_FIX = 64'd3373259426;
	localparam longint unsigned ONE_FIX = 64'd1073741824;

	logic [7:0] sin_lut [256];
	logic [7:0] cos_lut [256];
	pattern_t   cur_pattern;
	logic [7:0] cur_contrast;
	logic [7:0] expected_pixels [$];

	// one quarter wave of the grey-scaled sine, fixed point series
	function automatic int unsigned sine_quarter(int unsigned k);
		longint unsigned ang, sq, t;
		longint s;
		if (k == 0) return 127;
		if (k >= 64) return 255;
		ang = (longint'(k) * PI_FIX) >> 7;
		sq = (ang * ang) >> 30;
		t = ang;
		s = longint'(ang);
		for (int n = 1; n <= 10; n++) begin
			t = ((t * sq) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2) s -= longint'(t);
			else s += longint'(t);
		end
		if (s < 0) s = 0;
		if (s > longint'(ONE_FIX)) s = longint'(ONE_FIX);
		return int'(((ONE_FIX + longint'(s)) * 255) >> 31);
	endfunction

	initial begin
		int unsigned qw [65];
		int unsigned r, v;
		for (int k = 0; k <= 64; k++) qw[k] = sine_quarter(k);
		for (int i = 0; i < 256; i++) begin
			r = i % 64;
			case (i / 64)
				0: v = qw[r];
				1: v = qw[64 - r];
				2: v = 254 - qw[r];
				default: v = (r == 0) ? 0 : 254 - qw[64 - r];
			endcase
			sin_lut[i] = v[7:0];
		end
		for (int i = 0; i < 256; i++) cos_lut[i] = sin_lut[(i + 64) % 256];
	end

	function automatic logic [7:0] predict_pixel(pattern_t pat, logic [7:0] gain,
			logic [14:0] cx, logic [14:0] cy);
		logic [31:0] x, y, p;
		int centred;
		x = {17'd0, cx};
		y = {17'd0, cy};
		case (pat)
			PAT_TURN:      p = ((x + y) & 3) ? 32'd255 : 32'd0;
			PAT_FRACTAL:   p = (x - (x ^ y)) + (y - (x ^ y));
			PAT_XOR:       p = (x - y) ^ (y + x);
			PAT_SINE_XOR:  p = sin_lut[((x + y) ^ (y - x)) & 255]
					+ cos_lut[((x - y) ^ (y + x)) & 255];
			PAT_TRIANGLES: p = ((x ^ 145) + (y ^ 543)) ^ ((x ^ 342) + (y ^ 761));
			PAT_RECTS:     p = ((x ^ 32'he4a8) + (x ^ 32'h1e8b))
					^ ((y ^ 32'h193f) - (y ^ 32'h94e2));
			PAT_CUBES:     p = ((x - 32'h834e) ^ (y + 32'h2314))
					- ((y - 32'h23ab) ^ (x + 32'h11e9));
			PAT_SCOTLAND:  p = ((x | 32'h834e) + (x & 32'h2314))
					^ ((y & 32'h23ab) - (y | 32'h11e9));
			PAT_CHAOTIC:   p = (x ^ ((y & 255) << (x & 4))) + (y ^ ((x & 255) << (y & 4)));
			default:       p = 32'd128;
		endcase
		centred = int'(p & 255) - 128;
		centred = (centred * int'(gain)) / 255 + 128;
		return centred[7:0];
	endfunction

	assign pixels_waiting = expected_pixels.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pattern <= PAT_TURN;
			cur_contrast <= CONTRAST_RESET;
			fail_count <= 0;
			pixels_checked <= 0;
			expected_pixels.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_PATTERN) cur_pattern <= pattern_t'(cfg_data[3:0]);
				else if (cfg_index == REG_CONTRAST) cur_contrast <= cfg_data;
			end
			if (in_valid && in_ready)
				expected_pixels.push_back(predict_pixel(cur_pattern, cur_contrast,
					coord_x, coord_y));
			if (out_valid && out_ready) begin
				pixels_checked <= pixels_checked + 1;
				if (expected_pixels.size() == 0) begin
					$display("%t: unexpected pixel %0d, nothing outstanding", $time, pixel_value);
					fail_count <= fail_count + 1;
				end else begin
					if (pixel_value !== expected_pixels[0]) begin
						$display("%t: pixel_value expected %0d actual %0d", $time,
							expected_pixels[0], pixel_value);
						fail_count <= fail_count + 1;
					end
					void'(expected_pixels.pop_front());
				end
			end
		end
	end

endmodule

// ===== bench/tb_procedural_pattern_pixel_generator.sv =====
// Testbench top for the pattern generator: stimulus, register setup, idling phases, verdict.
module tb_procedural_pattern_pixel_generator;
	import ppg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [14:0] coord_x = '0;
	logic [14:0] coord_y = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  pixel_value;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	int          fail_count, pixels_waiting, pixels_checked;

	// idling mode: 0 none, 1 sender gaps, 2 receiver stalls, 3 both
	int          idle_mode = 0;
	int          settings_used = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	procedural_pattern_pixel_generator dut (.*);

	ppg_checker chk (.*);

	// receiver side: out_ready low with 80% probability in mode 2, 21% in mode 3 where both sides idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			case (idle_mode)
				2: out_ready <= ($urandom_range(99) >= 80);
				3: out_ready <= ($urandom_range(99) >= 21);
				default: out_ready <= 1'b1;
			endcase
		end
	end

	// one coordinate transaction; in_valid stays high straight into the next one if no gap
	task automatic send_coord(logic [14:0] cx, logic [14:0] cy);
		int gap;
		gap = 0;
		if (idle_mode == 1) begin
			while ($urandom_range(99) < 80) gap++;
		end else if (idle_mode == 3) begin
			while ($urandom_range(99) < 21) gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		coord_x <= cx;
		coord_y <= cy;
		do @(posedge clk); while (!in_ready);
	endtask

	// quiet the input, let every pixel drain through the 4-stage pipe, then keep idling before returning
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pixels_waiting != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_mode(logic [3:0] pat, logic [7:0] gain);
		wait_drained();
		write_reg(REG_PATTERN, {4'd0, pat});
		write_reg(REG_CONTRAST, gain);
		settings_used++;
	endtask

	initial begin
		logic [7:0] gain;
		logic [3:0] pat;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings first, then corner coordinates under each pattern
		send_coord(15'd0, 15'd0);
		send_coord(15'h7fff, 15'h7fff);
		send_coord(15'd1, 15'd2);
		for (int p = 0; p < 9; p++) begin
			set_mode(p[3:0], (p % 3 == 0) ? 8'd255 : (p % 3 == 1) ? 8'd1 : 8'd128);
			send_coord(15'h7fff, 15'd0);
			send_coord(15'h5555, 15'h2aaa);
		end
		// unused selector at full contrast
		set_mode(4'd15, 8'd255);
		send_coord(15'd3, 15'd7);
		// writes to an unimplemented index must change nothing; then zero contrast
		wait_drained();
		write_reg(reg_index_t'(2'd3), 8'hff);
		set_mode(4'd3, 8'd0);
		send_coord(15'd77, 15'd200);

		// random: segments of 50 with new settings and rotating idling modes
		for (int seg = 0; seg < 15; seg++) begin
			case (seg % 5)
				0: gain = 8'd255;
				1: gain = 8'd0;
				default: gain = 8'($urandom_range(255));
			endcase
			pat = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
				: 4'($urandom_range(8));
			set_mode(pat, gain);
			idle_mode = seg % 4;
			for (int n = 0; n < 50; n++) begin
				send_coord(15'($urandom_range(32767)), 15'($urandom_range(32767)));
				// sender holds off until the pipe is empty
				if (seg == 6 && n == 25) wait_drained();
			end
		end
		idle_mode = 0;
		wait_drained();

		$display("Covered %0d register settings, all nine patterns plus unused selectors,",
			settings_used);
		$display("%0d pixels checked under four idling modes.", pixels_checked);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
